@@ rtl/core/cpmc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpmc_pkg: shared types and constants
// Sizes, control codes and helper functions for the complement pattern counter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpmc_pkg;

  localparam int ROW_BITS     = 64;  // row field width
  localparam int WIDTH_BITS   = 7;   // row_width register width
  localparam int OUT_BITS     = 16;  // best_count field width
  localparam int MAX_PATTERNS = 64;
  localparam int MAX_COLS     = 64;
  localparam int COUNT_BITS   = 16;

  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(64);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE,
    ST_REPORT
  } state_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic clear;
    logic compare;
    logic update;
  } cell_ctrl_t;

  // Clip an internal count to the output field.
  function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    if (wide > 32'(COUNT_MAX) || wide > 32'({OUT_BITS{1'b1}})) begin
      sat_out = (wide > 32'({OUT_BITS{1'b1}})) ? {OUT_BITS{1'b1}} : wide[OUT_BITS-1:0];
    end else begin
      sat_out = wide[OUT_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cpmc_if.sv @@
// ----------------------------------------------------------------------------
// cpmc_if: channel interfaces
// Row request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpmc_row_if;
  logic                          valid;
  logic                          ready;
  logic [cpmc_pkg::ROW_BITS-1:0] row_bits;
  logic                          first_row;

  modport source (output valid, row_bits, first_row, input ready);
  modport sink   (input valid, row_bits, first_row, output ready);
endinterface

interface cpmc_res_if;
  logic                          valid;
  logic                          ready;
  logic [cpmc_pkg::OUT_BITS-1:0] best_count;
  logic                          table_overflow;

  modport source (output valid, best_count, table_overflow, input ready);
  modport sink   (input valid, best_count, table_overflow, output ready);
endinterface

interface cpmc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cpmc_pkg::WIDTH_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/complement_pattern_mode_counter.sv @@
// The result is registered: an accepted row steps through the compare, update
// and report states over the cell chain, and report waits on the result register.
// A new row is accepted only in idle, after that sequence completes.
// Reset (rst, synchronous): table empty, best count zero, row_width 64.
// The configuration channel is always ready.
// ----------------------------------------------------------------------------
// complement_pattern_mode_counter: top level
// Counts rows up to complement in a chain of pattern cells and reports the
// largest count so far.
// ----------------------------------------------------------------------------
`default_nettype none

module complement_pattern_mode_counter (
  input  wire logic clk,
  input  wire logic rst,
  cpmc_row_if.sink   rows,
  cpmc_res_if.source result,
  cpmc_cfg_if.sink   cfg
);

  localparam int N = cpmc_pkg::MAX_PATTERNS;

  cpmc_pkg::state_t     state, state_next;
  cpmc_pkg::cell_ctrl_t ctrl;

  logic [cpmc_pkg::WIDTH_BITS-1:0] row_width;
  logic [cpmc_pkg::ROW_BITS-1:0]   canon;
  logic [cpmc_pkg::ROW_BITS-1:0]   row_q;
  logic                            clear_q;
  logic                            hit_q;
  logic                            ovf_q;
  logic [cpmc_pkg::COUNT_BITS-1:0] best;
  logic [cpmc_pkg::COUNT_BITS-1:0] cand;
  logic [cpmc_pkg::COUNT_BITS-1:0] hit_count;
  logic                            out_free;
  logic                            accept;
  logic                            any_hit;

  logic [N-1:0]                            cell_valid;
  logic [N-1:0]                            cell_match;
  logic [N-1:0]                            prev_valid;
  logic [N-1:0][cpmc_pkg::COUNT_BITS-1:0]  cell_count;

  assign cfg.ready = 1'b1;
  assign out_free  = !result.valid || result.ready;
  assign accept    = rows.valid && rows.ready;
  assign any_hit   = |cell_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= cpmc_pkg::WIDTH_RESET;
    end else if (cfg.valid) begin
      row_width <= cfg.data;
    end
  end

  cpmc_canon u_canon (
    .row_width (row_width),
    .row_bits  (rows.row_bits),
    .canon     (canon)
  );

  // cell 0 is the first to allocate; each cell waits on its left neighbor
  assign prev_valid = {cell_valid[N-2:0], 1'b1};

  for (genvar g = 0; g < N; g++) begin : g_cell
    cpmc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .row        (row_q),
      .any_hit    (any_hit),
      .prev_valid (prev_valid[g]),
      .valid      (cell_valid[g]),
      .match      (cell_match[g]),
      .hit_count  (cell_count[g])
    );
  end

  always_comb begin
    hit_count = '0;
    for (int i = 0; i < N; i++) begin
      hit_count = hit_count | cell_count[i];
    end
  end

  always_comb begin
    if (hit_q) begin
      cand = hit_count;
    end else if (ovf_q) begin
      cand = '0;
    end else begin
      cand = cpmc_pkg::COUNT_BITS'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cpmc_pkg::ST_IDLE:    if (accept) state_next = cpmc_pkg::ST_COMPARE;
      cpmc_pkg::ST_COMPARE: state_next = cpmc_pkg::ST_UPDATE;
      cpmc_pkg::ST_UPDATE:  state_next = cpmc_pkg::ST_REPORT;
      cpmc_pkg::ST_REPORT:  if (out_free) state_next = cpmc_pkg::ST_IDLE;
      default:              state_next = cpmc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rows.ready   = 1'b0;
    ctrl.clear   = clear_q;
    ctrl.compare = 1'b0;
    ctrl.update  = 1'b0;
    case (state)
      cpmc_pkg::ST_IDLE:    rows.ready   = 1'b1;
      cpmc_pkg::ST_COMPARE: ctrl.compare = 1'b1;
      cpmc_pkg::ST_UPDATE:  ctrl.update  = 1'b1;
      default:              ctrl.compare = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpmc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_q   <= canon;
      clear_q <= rows.first_row;
    end
    if (state == cpmc_pkg::ST_UPDATE) begin
      hit_q <= any_hit;
      ovf_q <= !any_hit && cell_valid[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best         <= '0;
      result.valid <= 1'b0;
    end else begin
      if (state == cpmc_pkg::ST_COMPARE && clear_q) begin
        best <= '0;
      end
      if (state == cpmc_pkg::ST_REPORT && out_free) begin
        // fold the new candidate into the running best and publish
        if (cand > best) begin
          best <= cand;
        end
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cpmc_pkg::ST_REPORT && out_free) begin
      result.best_count     <= cpmc_pkg::sat_out((cand > best) ? cand : best);
      result.table_overflow <= ovf_q;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/cpmc_canon.sv @@
// ----------------------------------------------------------------------------
// cpmc_canon: row canonicalizer
// Masks a row to the configured column count and inverts it when column 0 is set.
// ----------------------------------------------------------------------------
`default_nettype none

module cpmc_canon (
  input  wire logic [cpmc_pkg::WIDTH_BITS-1:0] row_width,
  input  wire logic [cpmc_pkg::ROW_BITS-1:0]   row_bits,
  output logic      [cpmc_pkg::ROW_BITS-1:0]   canon
);

  logic [cpmc_pkg::WIDTH_BITS-1:0] width_eff;
  logic [cpmc_pkg::WIDTH_BITS-1:0] shift;
  logic [cpmc_pkg::ROW_BITS-1:0]   mask;
  logic [cpmc_pkg::ROW_BITS-1:0]   masked;

  always_comb begin
    // clamp to 1..MAX_COLS
    if (row_width == '0) begin
      width_eff = cpmc_pkg::WIDTH_BITS'(1);
    end else if (row_width > cpmc_pkg::WIDTH_BITS'(cpmc_pkg::MAX_COLS)) begin
      width_eff = cpmc_pkg::WIDTH_BITS'(cpmc_pkg::MAX_COLS);
    end else begin
      width_eff = row_width;
    end
    shift  = cpmc_pkg::WIDTH_BITS'(cpmc_pkg::ROW_BITS) - width_eff;
    mask   = {cpmc_pkg::ROW_BITS{1'b1}} >> shift;
    masked = row_bits & mask;
    canon  = masked[0] ? (~masked & mask) : masked;
  end

endmodule

`default_nettype wire

@@ rtl/core/cpmc_cell.sv @@
// ----------------------------------------------------------------------------
// cpmc_cell: one pattern table entry
// Holds a pattern and its count, matches the broadcast row, and allocates
// itself when it is the first free entry after its valid neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module cpmc_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cpmc_pkg::cell_ctrl_t              ctrl,
  input  wire logic [cpmc_pkg::ROW_BITS-1:0]     row,
  input  wire logic                              any_hit,
  input  wire logic                              prev_valid,
  output logic                                   valid,
  output logic                                   match,
  output logic      [cpmc_pkg::COUNT_BITS-1:0]   hit_count
);

  logic [cpmc_pkg::ROW_BITS-1:0]   pattern;
  logic [cpmc_pkg::COUNT_BITS-1:0] count;
  logic                            alloc;

  assign alloc     = ctrl.update && !any_hit && !valid && prev_valid;
  assign hit_count = match ? count : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else if (ctrl.compare) begin
      if (ctrl.clear) begin
        valid <= 1'b0;
      end
      match <= valid && !ctrl.clear && (pattern == row);
    end else if (alloc) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update && match) begin
      if (count != cpmc_pkg::COUNT_MAX) begin
        count <= count + cpmc_pkg::COUNT_BITS'(1);
      end
    end else if (alloc) begin
      pattern <= row;
      count   <= cpmc_pkg::COUNT_BITS'(1);
    end
  end

endmodule

`default_nettype wire
